// ===== design/gdnc_pkg.sv =====
// Shared types, constants and tables for the Gregorian day number converter.
// Holds the microcode program, control word and result types and the calendar tables.
// No dependencies.
package gdnc_pkg;

	localparam int unsigned PC_W = 4;

	localparam logic [13:0] YEAR_MAX    = 14'd9999;
	localparam logic [21:0] SPAN_FIRST  = 22'd366;
	localparam logic [21:0] SPAN_LAST   = 22'd3652424;
	localparam logic [21:0] CYCLE_DAYS  = 22'd146097;
	localparam logic [21:0] CYCLE_YEARS = 22'd400;
	localparam logic [21:0] YEAR_DAYS   = 22'd365;
	localparam logic [21:0] CYCLE_LEAPS = 22'd97;
	localparam logic [21:0] WD_OFFSET   = 22'd6;
	localparam logic [3:0]  MONTHS      = 4'd12;

	// datapath operations, carried out only when the step's condition holds
	typedef enum logic [3:0] {
		OP_NOP,
		OP_SUB400,
		OP_SET_T,
		OP_CNT_YEAR,
		OP_CNT_CYC,
		OP_CNT_MON,
		OP_SUB_CYCLE,
		OP_SUB_YEAR,
		OP_SUB_MONTH,
		OP_WEEKDAY,
		OP_DONE,
		OP_FAIL
	} op_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_MODE1,
		C_DATE_BAD,
		C_GE_400,
		C_DAY_BAD,
		C_SPAN_BAD,
		C_GE_CYCLE,
		C_GE_YEAR,
		C_MONTH_FITS
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic [21:0] day_count;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  week_day;
		logic        valid_res;
	} res_t;

	// program addresses
	localparam logic [PC_W-1:0] PC_DISPATCH  = 4'd0;
	localparam logic [PC_W-1:0] PC_DATE_CHK  = 4'd1;
	localparam logic [PC_W-1:0] PC_Y_CYCLES  = 4'd2;
	localparam logic [PC_W-1:0] PC_SET_T     = 4'd3;
	localparam logic [PC_W-1:0] PC_DAY_CHK   = 4'd4;
	localparam logic [PC_W-1:0] PC_CNT_YEAR  = 4'd5;
	localparam logic [PC_W-1:0] PC_CNT_CYC   = 4'd6;
	localparam logic [PC_W-1:0] PC_CNT_MON   = 4'd7;
	localparam logic [PC_W-1:0] PC_SPAN_CHK  = 4'd8;
	localparam logic [PC_W-1:0] PC_N_CYCLES  = 4'd9;
	localparam logic [PC_W-1:0] PC_N_YEARS   = 4'd10;
	localparam logic [PC_W-1:0] PC_N_MONTHS  = 4'd11;
	localparam logic [PC_W-1:0] PC_WEEKDAY   = 4'd12;
	localparam logic [PC_W-1:0] PC_DONE      = 4'd13;
	localparam logic [PC_W-1:0] PC_FAIL      = 4'd14;

	// control store: a taken condition runs the op and jumps, otherwise fall through
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			PC_DISPATCH: w = '{op: OP_NOP,       cond: C_MODE1,      target: PC_SPAN_CHK};
			PC_DATE_CHK: w = '{op: OP_NOP,       cond: C_DATE_BAD,   target: PC_FAIL};
			PC_Y_CYCLES: w = '{op: OP_SUB400,    cond: C_GE_400,     target: PC_Y_CYCLES};
			PC_SET_T:    w = '{op: OP_SET_T,     cond: C_ALWAYS,     target: PC_DAY_CHK};
			PC_DAY_CHK:  w = '{op: OP_NOP,       cond: C_DAY_BAD,    target: PC_FAIL};
			PC_CNT_YEAR: w = '{op: OP_CNT_YEAR,  cond: C_ALWAYS,     target: PC_CNT_CYC};
			PC_CNT_CYC:  w = '{op: OP_CNT_CYC,   cond: C_ALWAYS,     target: PC_CNT_MON};
			PC_CNT_MON:  w = '{op: OP_CNT_MON,   cond: C_ALWAYS,     target: PC_WEEKDAY};
			PC_SPAN_CHK: w = '{op: OP_NOP,       cond: C_SPAN_BAD,   target: PC_FAIL};
			PC_N_CYCLES: w = '{op: OP_SUB_CYCLE, cond: C_GE_CYCLE,   target: PC_N_CYCLES};
			PC_N_YEARS:  w = '{op: OP_SUB_YEAR,  cond: C_GE_YEAR,    target: PC_N_YEARS};
			PC_N_MONTHS: w = '{op: OP_SUB_MONTH, cond: C_MONTH_FITS, target: PC_N_MONTHS};
			PC_WEEKDAY:  w = '{op: OP_WEEKDAY,   cond: C_ALWAYS,     target: PC_DONE};
			PC_DONE:     w = '{op: OP_DONE,      cond: C_ALWAYS,     target: PC_DISPATCH};
			PC_FAIL:     w = '{op: OP_FAIL,      cond: C_ALWAYS,     target: PC_DISPATCH};
			default:     w = '{op: OP_FAIL,      cond: C_ALWAYS,     target: PC_DISPATCH};
		endcase
		return w;
	endfunction

	// leap rule for a year counted from the start of a 400-year cycle (0..400)
	function automatic logic cycle_year_leap(input logic [8:0] c);
		return (c[1:0] == 2'b00) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
			4'd2:                                      n = 5'd28 + 5'(leap);
			default:                                   n = 5'd0;
		endcase
		return n;
	endfunction

	// days in a common year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// remainder by 7: fold octal digits, since 8 leaves 1
	function automatic logic [2:0] mod7(input logic [21:0] v);
		logic [23:0] w;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [3:0]  s3;
		w  = {2'b00, v};
		s1 = 6'd0;
		for (int i = 0; i < 8; i++) begin
			s1 = s1 + 6'(w[3*i +: 3]);
		end
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		s3 = 4'(s2[2:0]) + 4'(s2[3]);
		return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
	endfunction

endpackage

// ===== design/gregorian_day_number_converter_unit.sv =====
// Top level of the Gregorian day number converter: sequencer, control store, output register.
// Instantiates gdnc_datapath; uses gdnc_pkg.
//
// A beat in mode 0 turns a date into its serial day count (366 is 1 January of year 1) and
// splits (year - 1) into 400-year cycles one per cycle. A beat in mode 1 turns a day count
// into a date by peeling off the 400-year cycles (up to 24), the years within the last cycle
// (up to 399) and the months, with one closing check for each loop, all stepped by the
// microcode sequencer. A year, month or zero day out of range, or a day count out of span, is
// rejected by a check before any loop runs; a day past the end of its month is found only
// after the year split. Rejected results carry valid_res low and every other field zero. One
// beat is worked at a time; the next is taken the cycle after the result is loaded into the
// output register, and a stalled result holds the program on its last step.
module gregorian_day_number_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [21:0] day_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [21:0] day_count,
	output logic [13:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [2:0]  week_day,
	output logic        valid_res
);

	logic                      busy_q;
	logic [gdnc_pkg::PC_W-1:0] pc_q;
	logic                      out_valid_q;
	gdnc_pkg::res_t            res_q;

	gdnc_pkg::ctrl_t           word;
	gdnc_pkg::res_t            res;
	logic                      cond_hit;
	logic                      load;
	logic                      fin_op;
	logic                      out_free;
	logic                      step_en;

	assign word     = gdnc_pkg::ucode(pc_q);
	assign load     = in_valid && !busy_q;
	assign fin_op   = (word.op == gdnc_pkg::OP_DONE) || (word.op == gdnc_pkg::OP_FAIL);
	assign out_free = !out_valid_q || !out_stall;
	// hold the last step until the output register can take the beat
	assign step_en  = busy_q && (!fin_op || out_free);

	gdnc_datapath u_datapath (
		.clk        (clk),
		.load       (load),
		.mode       (mode),
		.year       (year),
		.month      (month),
		.day        (day),
		.day_number (day_number),
		.exec       (step_en),
		.ctrl       (word),
		.cond_hit   (cond_hit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= gdnc_pkg::PC_DISPATCH;
			out_valid_q <= 1'b0;
		end else begin
			if (step_en && fin_op) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				pc_q   <= gdnc_pkg::PC_DISPATCH;
			end else if (step_en) begin
				if (fin_op) begin
					busy_q <= 1'b0;
				end else if (cond_hit) begin
					pc_q <= word.target;
				end else begin
					pc_q <= pc_q + gdnc_pkg::PC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && fin_op) begin
			res_q <= res;
		end
	end

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign day_count = res_q.day_count;
	assign out_year  = res_q.out_year;
	assign out_month = res_q.out_month;
	assign out_day   = res_q.out_day;
	assign week_day  = res_q.week_day;
	assign valid_res = res_q.valid_res;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (busy_q && pc_q == gdnc_pkg::PC_DISPATCH))
		else $error("accepted beat did not start the program");

	a_finish_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && fin_op && out_valid_q && out_stall) |=> (busy_q && $stable(pc_q)))
		else $error("program finished over a stalled result");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (day_count == 22'd0 && out_year == 14'd0
			&& out_month == 4'd0 && out_day == 5'd0 && week_day == 3'd0))
		else $error("rejected result carries non-zero fields");

	a_legal_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res) |-> (out_month >= 4'd1 && out_month <= 4'd12
			&& out_day != 5'd0 && week_day <= 3'd6 && out_year != 14'd0))
		else $error("accepted result is not a legal date");

endmodule

// ===== design/gdnc_datapath.sv =====
// Datapath of the day number converter: working registers, condition flags, operations.
// Fed one control word a cycle, bar stalls, by the top-level sequencer; uses gdnc_pkg.
module gdnc_datapath (
	input  logic              clk,
	input  logic              load,
	input  logic              mode,
	input  logic [13:0]       year,
	input  logic [3:0]        month,
	input  logic [4:0]        day,
	input  logic [21:0]       day_number,
	input  logic              exec,
	input  gdnc_pkg::ctrl_t   ctrl,
	output logic              cond_hit,
	output gdnc_pkg::res_t    res
);

	logic        mode_q;
	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [21:0] acc_q;
	logic [21:0] cnt_q;
	logic [4:0]  cyc_q;
	logic [8:0]  yic_q;
	logic [3:0]  mon_q;
	logic [2:0]  wd_q;

	logic        leap;
	logic [8:0]  year_len;
	logic [4:0]  dim_mon;
	logic [4:0]  dim_in;
	logic [8:0]  c_low;
	logic [1:0]  c_cent;
	logic [21:0] year_days;
	logic        feb_extra;

	assign leap      = gdnc_pkg::cycle_year_leap(yic_q);
	assign year_len  = 9'd365 + 9'(leap);
	assign dim_mon   = gdnc_pkg::days_in_month(mon_q, leap);
	assign dim_in    = gdnc_pkg::days_in_month(month_q, leap);
	// in date mode the accumulator ends as (year - 1) mod 400
	assign c_low     = acc_q[8:0];
	assign c_cent    = 2'(c_low >= 9'd100) + 2'(c_low >= 9'd200) + 2'(c_low >= 9'd300);
	assign year_days = 22'(year_q) * gdnc_pkg::YEAR_DAYS;
	assign feb_extra = leap && (month_q > 4'd2);

	always_comb begin
		case (ctrl.cond)
			gdnc_pkg::C_ALWAYS:     cond_hit = 1'b1;
			gdnc_pkg::C_MODE1:      cond_hit = mode_q;
			gdnc_pkg::C_DATE_BAD:   cond_hit = (year_q == 14'd0) || (year_q > gdnc_pkg::YEAR_MAX)
				|| (month_q == 4'd0) || (month_q > gdnc_pkg::MONTHS) || (day_q == 5'd0);
			gdnc_pkg::C_GE_400:     cond_hit = acc_q >= gdnc_pkg::CYCLE_YEARS;
			gdnc_pkg::C_DAY_BAD:    cond_hit = day_q > dim_in;
			gdnc_pkg::C_SPAN_BAD:   cond_hit = (cnt_q < gdnc_pkg::SPAN_FIRST)
				|| (cnt_q > gdnc_pkg::SPAN_LAST);
			gdnc_pkg::C_GE_CYCLE:   cond_hit = acc_q >= gdnc_pkg::CYCLE_DAYS;
			gdnc_pkg::C_GE_YEAR:    cond_hit = acc_q >= 22'(year_len);
			gdnc_pkg::C_MONTH_FITS: cond_hit = (mon_q < gdnc_pkg::MONTHS) && (acc_q >= 22'(dim_mon));
			default:                cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mode_q  <= mode;
			year_q  <= year;
			month_q <= month;
			day_q   <= day;
			acc_q   <= mode ? day_number : 22'(year - 14'd1);
			cnt_q   <= day_number;
			cyc_q   <= 5'd0;
			yic_q   <= 9'd0;
			mon_q   <= 4'd1;
		end else if (exec && cond_hit) begin
			case (ctrl.op)
				gdnc_pkg::OP_NOP: begin
				end
				gdnc_pkg::OP_SUB400: begin
					acc_q <= acc_q - gdnc_pkg::CYCLE_YEARS;
					cyc_q <= cyc_q + 5'd1;
				end
				gdnc_pkg::OP_SET_T: begin
					yic_q <= c_low + 9'd1;
				end
				gdnc_pkg::OP_CNT_YEAR: begin
					cnt_q <= year_days;
				end
				gdnc_pkg::OP_CNT_CYC: begin
					cnt_q <= cnt_q + 22'(cyc_q) * gdnc_pkg::CYCLE_LEAPS + 22'(c_low[8:2])
						- 22'(c_cent);
				end
				gdnc_pkg::OP_CNT_MON: begin
					cnt_q <= cnt_q + 22'(gdnc_pkg::days_before(month_q)) + 22'(feb_extra)
						+ 22'(day_q);
				end
				gdnc_pkg::OP_SUB_CYCLE: begin
					acc_q <= acc_q - gdnc_pkg::CYCLE_DAYS;
					cyc_q <= cyc_q + 5'd1;
				end
				gdnc_pkg::OP_SUB_YEAR: begin
					acc_q <= acc_q - 22'(year_len);
					yic_q <= yic_q + 9'd1;
				end
				gdnc_pkg::OP_SUB_MONTH: begin
					acc_q <= acc_q - 22'(dim_mon);
					mon_q <= mon_q + 4'd1;
				end
				gdnc_pkg::OP_WEEKDAY: begin
					wd_q <= gdnc_pkg::mod7(cnt_q + gdnc_pkg::WD_OFFSET);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (ctrl.op == gdnc_pkg::OP_FAIL) begin
			res = '0;
		end else begin
			res.day_count = cnt_q;
			res.out_year  = mode_q ? 14'(cyc_q) * 14'd400 + 14'(yic_q) : year_q;
			res.out_month = mode_q ? mon_q : month_q;
			res.out_day   = mode_q ? acc_q[4:0] + 5'd1 : day_q;
			res.week_day  = wd_q;
			res.valid_res = 1'b1;
		end
	end

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for gregorian_day_number_converter_unit: date to day count and back.
// Drives beats from a queue and scores each result against a calendar predictor kept here.
// Depends on gdnc_pkg (result type) and the converter RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_TO_COUNT = 1'b0;
	localparam logic MODE_TO_DATE  = 1'b1;

	localparam int unsigned RANDOM_BEATS  = 650;
	localparam int unsigned SETTLE_CYCLES = 500;
	localparam int unsigned CYCLE_LIMIT   = 1_500_000;

	typedef struct {
		logic        mode;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [21:0] day_number;
		bit          drain;
	} beat_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        mode       = MODE_TO_COUNT;
	logic [13:0] year       = '0;
	logic [3:0]  month      = '0;
	logic [4:0]  day        = '0;
	logic [21:0] day_number = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [21:0] day_count;
	logic [13:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [2:0]  week_day;
	logic        valid_res;

	beat_t           beats_to_send[$];
	gdnc_pkg::res_t  due_results[$];

	logic        in_taken = 1'b0;
	int unsigned send_gap = 0;
	int unsigned free_left = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned to_count_sent = 0;
	int unsigned to_date_sent = 0;
	int unsigned results_seen = 0;
	int unsigned rejected_seen = 0;

	gregorian_day_number_converter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.year       (year),
		.month      (month),
		.day        (day),
		.day_number (day_number),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.day_count  (day_count),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day),
		.week_day   (week_day),
		.valid_res  (valid_res)
	);

	function automatic int unsigned leap_year(input int unsigned y);
		return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return 28 + leap_year(y);
			default:               return 0;
		endcase
	endfunction

	function automatic gdnc_pkg::res_t calendar_convert(input logic md, input logic [13:0] yr,
			input logic [3:0] mo, input logic [4:0] dy, input logic [21:0] dn);
		gdnc_pkg::res_t r;
		int unsigned    cnt, oy, om, od, rest, tm, ty, sum;
		bit             ok;
		r   = '0;
		cnt = 0;
		oy  = 0;
		om  = 0;
		od  = 0;
		if (md == MODE_TO_COUNT) begin
			oy = yr;
			om = mo;
			od = dy;
			ok = oy >= 1 && oy <= 9999 && om >= 1 && om <= 12 && od >= 1 &&
				od <= month_days(oy, om);
			if (ok) begin
				cnt = oy * 365 + (oy - 1) / 4 - (oy - 1) / 100 + (oy - 1) / 400 + od;
				for (int i = 1; i < om; i++)
					cnt += month_days(oy, i);
			end
		end else begin
			cnt = dn;
			ok  = cnt >= 366 && cnt <= 3652424;
			if (ok) begin
				// peel whole 400-year cycles, then single years, then months
				rest = cnt % 146097;
				oy   = (cnt / 146097) * 400;
				om   = 1;
				while (rest >= 365 + leap_year(oy)) begin
					rest -= 365 + leap_year(oy);
					oy++;
				end
				while (om < 12 && rest >= month_days(oy, om)) begin
					rest -= month_days(oy, om);
					om++;
				end
				od = rest + 1;
			end
		end
		if (ok) begin
			// January and February count as months 11 and 12 of the previous year
			tm  = (om >= 3) ? om - 2 : om + 10;
			ty  = (om >= 3) ? oy : oy - 1;
			sum = ty + ty / 4 - ty / 100 + ty / 400 + (26 * tm - 2) / 10 + od;
			r.day_count = 22'(cnt);
			r.out_year  = 14'(oy);
			r.out_month = 4'(om);
			r.out_day   = 5'(od);
			r.week_day  = 3'(sum % 7);
			r.valid_res = 1'b1;
		end
		return r;
	endfunction

	// mostly back to back, sometimes a few cycles, now and then a long pause
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_beat(input logic md, input int unsigned y, input int unsigned m,
			input int unsigned d, input int unsigned n, input bit hold);
		beat_t b;
		b.mode       = md;
		b.year       = 14'(y);
		b.month      = 4'(m);
		b.day        = 5'(d);
		b.day_number = 22'(n);
		b.drain      = hold;
		beats_to_send = {beats_to_send, b};
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				due_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// input driver: hold a beat until taken, then idle or advance
	always @(negedge clk) begin
		beat_t b;
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_taken)
				send_gap = idle_len();
			if (send_gap > 0 || beats_to_send.size() == 0 ||
					(beats_to_send[0].drain && due_results.size() != 0)) begin
				in_valid <= 1'b0;
				if (send_gap > 0)
					send_gap--;
			end else begin
				b = beats_to_send.pop_front();
				mode       <= b.mode;
				year       <= b.year;
				month      <= b.month;
				day        <= b.day;
				day_number <= b.day_number;
				in_valid   <= 1'b1;
			end
		end
	end

	// result stall: free runs of random length broken by stalls
	always @(negedge clk) begin
		if (free_left > 0) begin
			out_stall <= 1'b0;
			free_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			free_left  = ($urandom_range(9) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 20);
			stall_left = idle_len();
			out_stall <= 1'b0;
		end
	end

	// monitor: predict on each input beat, score each result beat
	always @(posedge clk) begin
		gdnc_pkg::res_t want;
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			due_results = {due_results,
				calendar_convert(mode, year, month, day, day_number)};
			if (mode == MODE_TO_DATE)
				to_date_sent++;
			else
				to_count_sent++;
		end
		if (out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result beat with nothing due: day_count %0d valid_res %0b",
					day_count, valid_res);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				results_seen++;
				if (!want.valid_res)
					rejected_seen++;
				if (day_count !== want.day_count) begin
					$error("day_count: expected %0d, got %0d", want.day_count, day_count);
					mismatches++;
				end
				if (out_year !== want.out_year) begin
					$error("out_year: expected %0d, got %0d", want.out_year, out_year);
					mismatches++;
				end
				if (out_month !== want.out_month) begin
					$error("out_month: expected %0d, got %0d", want.out_month, out_month);
					mismatches++;
				end
				if (out_day !== want.out_day) begin
					$error("out_day: expected %0d, got %0d", want.out_day, out_day);
					mismatches++;
				end
				if (week_day !== want.week_day) begin
					$error("week_day: expected %0d, got %0d", want.week_day, week_day);
					mismatches++;
				end
				if (valid_res !== want.valid_res) begin
					$error("valid_res: expected %0b, got %0b", want.valid_res, valid_res);
					mismatches++;
				end
			end
		end
	end

	initial begin
		beat_t          b;
		gdnc_pkg::res_t known;
		int unsigned    y, m, d, pick;

		// directed: calendar edges, leap rules, rejected dates and out-of-span counts
		queue_beat(MODE_TO_COUNT, 1, 1, 1, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 9999, 12, 31, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2000, 2, 29, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 1900, 2, 29, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2024, 2, 29, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2023, 2, 29, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2023, 4, 31, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2023, 0, 10, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2023, 13, 1, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 16383, 15, 31, 22'h3FFFFF, 1'b0);
		queue_beat(MODE_TO_COUNT, 0, 1, 1, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 10000, 1, 1, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 2023, 6, 0, 0, 1'b0);
		queue_beat(MODE_TO_COUNT, 400, 12, 31, 0, 1'b1);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 0, 1'b0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 365, 1'b0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 366, 1'b0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 3652424, 1'b0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 3652425, 1'b0);
		queue_beat(MODE_TO_DATE, 16383, 15, 31, 22'h3FFFFF, 1'b0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 146097, 1'b0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, 146096, 1'b0);
		known = calendar_convert(MODE_TO_COUNT, 14'd2000, 4'd2, 5'd29, 22'd0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, known.day_count, 1'b0);
		known = calendar_convert(MODE_TO_COUNT, 14'd1600, 4'd12, 5'd31, 22'd0);
		queue_beat(MODE_TO_DATE, 0, 0, 0, known.day_count, 1'b0);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// unused fields carry noise in every beat
			b.mode       = 1'($urandom);
			b.year       = 14'($urandom);
			b.month      = 4'($urandom);
			b.day        = 5'($urandom);
			b.day_number = 22'($urandom);
			b.drain      = (i == RANDOM_BEATS / 2);
			case ($urandom_range(3))
				0:       y = $urandom_range(1, 9999);
				1:       y = 100 * $urandom_range(1, 99) + $urandom_range(2) - 1;
				2:       y = $urandom_range(1) ? $urandom_range(1, 12) : $urandom_range(9988, 9999);
				default: y = 4 * $urandom_range(1, 2499);
			endcase
			m = $urandom_range(1, 12);
			d = $urandom_range(1, month_days(y, m));
			pick = $urandom_range(99);
			if (pick < 50) begin
				b.mode = MODE_TO_COUNT;
				if (pick < 30) begin
					b.year  = 14'(y);
					b.month = 4'(m);
					b.day   = 5'(d);
				end else if (pick < 40) begin
					b.year  = 14'(y);
					b.month = 4'(m);
					b.day   = 5'(month_days(y, m) + $urandom_range(1));
				end
			end else begin
				b.mode = MODE_TO_DATE;
				if (pick < 70) begin
					known = calendar_convert(MODE_TO_COUNT, 14'(y), 4'(m), 5'(d), 22'd0);
					b.day_number = 22'(known.day_count + $urandom_range(2) - 1);
				end else if (pick < 88) begin
					b.day_number = 22'($urandom_range(366, 3652424));
				end
			end
			beats_to_send = {beats_to_send, b};
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_to_send.size() != 0 || in_valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d date-to-count and %0d count-to-date beats sent in %0d cycles",
			to_count_sent, to_date_sent, cycle_count);
		$display("%0d results scored, %0d of them rejected inputs, %0d field mismatches",
			results_seen, rejected_seen, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/gdnc_pkg.sv
design/gdnc_datapath.sv
design/gregorian_day_number_converter_unit.sv
dv/tb.sv
